/* rtl/siq_pkg.sv */
// Shared types and codes for the searchable integer queue.
package siq_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned FILL_W  = 7;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_POP    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_EXISTS = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    kind_e                      kind;
    logic signed [VALUE_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  popped_value;
    logic                       found;
    logic                       now_empty;
    logic [FILL_W-1:0]          fill_count;
    status_e                    status;
  } result_t;

endpackage

/* rtl/searchable_int_queue.sv */
// Bounded ordered integer queue with append, pop, remove-all and search.
//
//  channel   | ports                  | handshake
//  ----------+------------------------+-----------------------------------
//  command   | cmd_i                  | beat taken when start_i & !busy_o
//  result    | res_o                  | beat on the cycle done_o is high
//
//  Append and pop need no scan; remove and exists scan the stored entries:
//  the scan reads one entry per cycle from the single read port of the
//  entry memory, drains the last read from its data register in the
//  following cycle, and remove writes kept entries back through its one
//  write port. Reset clears the head pointer, fill count and control state; the entry
//  memory needs no clearing pass. Results cannot be stalled by the receiver.
module searchable_int_queue #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  siq_pkg::cmd_t      cmd_i,
  output logic               busy_o,
  output logic               done_o,
  output siq_pkg::result_t   res_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W:0] CAP_S = (CNT_W + 1)'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SCAN
  } state_e;

  function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    begin
      s = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
      if (s >= CAP_S) begin
        s = s - CAP_S;
      end
      return s[IDX_W-1:0];
    end
  endfunction

  logic [siq_pkg::VALUE_W-1:0] mem [CAPACITY];

  state_e                        state_q;
  logic [IDX_W-1:0]              head_q;
  logic [CNT_W-1:0]              count_q;
  logic [CNT_W-1:0]              rd_idx_q;
  logic [CNT_W-1:0]              kept_q;
  logic                          rd_pend_q;
  logic                          found_q;
  siq_pkg::kind_e                kind_q;
  logic [siq_pkg::VALUE_W-1:0]   value_q;
  logic [siq_pkg::VALUE_W-1:0]   rd_data_q;
  logic                          done_q;
  siq_pkg::result_t              res_q;

  logic                          accept;
  logic                          rd_en;
  logic [IDX_W-1:0]              rd_addr;
  logic                          we;
  logic [IDX_W-1:0]              wa;
  logic [siq_pkg::VALUE_W-1:0]   wd;
  logic                          scan_more;
  logic                          match;

  assign busy_o    = (state_q != S_IDLE);
  assign accept    = start_i && !busy_o;
  assign scan_more = (rd_idx_q < count_q);
  assign match     = (rd_data_q == value_q);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head_q;
    if (accept && (cmd_i.kind == siq_pkg::KIND_POP)) begin
      rd_en   = 1'b1;
      rd_addr = head_q;
    end else if ((state_q == S_SCAN) && scan_more) begin
      rd_en   = 1'b1;
      rd_addr = wrap_add(head_q, rd_idx_q);
    end
  end

  always_comb begin
    we = 1'b0;
    wa = wrap_add(head_q, count_q);
    wd = cmd_i.value;
    if (accept && (cmd_i.kind == siq_pkg::KIND_APPEND) && (count_q != CAP_C)) begin
      we = 1'b1;
    end else if ((state_q == S_SCAN) && rd_pend_q && (kind_q == siq_pkg::KIND_REMOVE)
                 && !match) begin
      we = 1'b1;
      wa = wrap_add(head_q, kept_q);
      wd = rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      rd_idx_q  <= '0;
      kept_q    <= '0;
      rd_pend_q <= 1'b0;
      found_q   <= 1'b0;
      kind_q    <= siq_pkg::KIND_APPEND;
      value_q   <= '0;
      done_q    <= 1'b0;
      res_q     <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            kind_q    <= cmd_i.kind;
            value_q   <= cmd_i.value;
            rd_idx_q  <= '0;
            kept_q    <= '0;
            rd_pend_q <= 1'b0;
            found_q   <= 1'b0;
            case (cmd_i.kind)
              siq_pkg::KIND_APPEND: begin
                done_q                 <= 1'b1;
                res_q.popped_value     <= '0;
                res_q.found            <= 1'b0;
                if (count_q == CAP_C) begin
                  res_q.status     <= siq_pkg::ST_FULL;
                  res_q.now_empty  <= (count_q == '0);
                  res_q.fill_count <= siq_pkg::FILL_W'(count_q);
                end else begin
                  count_q          <= count_q + 1'b1;
                  res_q.status     <= siq_pkg::ST_OK;
                  res_q.now_empty  <= 1'b0;
                  res_q.fill_count <= siq_pkg::FILL_W'(count_q + 1'b1);
                end
              end
              siq_pkg::KIND_POP: begin
                if (count_q == '0) begin
                  done_q             <= 1'b1;
                  res_q.popped_value <= '0;
                  res_q.found        <= 1'b0;
                  res_q.now_empty    <= 1'b1;
                  res_q.fill_count   <= '0;
                  res_q.status       <= siq_pkg::ST_POP_EMPTY;
                end else begin
                  state_q <= S_POP;
                end
              end
              default: begin
                state_q <= S_SCAN;
              end
            endcase
          end
        end
        S_POP: begin
          state_q            <= S_IDLE;
          head_q             <= wrap_add(head_q, CNT_W'(1));
          count_q            <= count_q - 1'b1;
          done_q             <= 1'b1;
          res_q.popped_value <= $signed(rd_data_q);
          res_q.found        <= 1'b0;
          res_q.now_empty    <= (count_q == CNT_W'(1));
          res_q.fill_count   <= siq_pkg::FILL_W'(count_q - 1'b1);
          res_q.status       <= siq_pkg::ST_OK;
        end
        S_SCAN: begin
          rd_pend_q <= scan_more;
          if (scan_more) begin
            rd_idx_q <= rd_idx_q + 1'b1;
          end
          if (rd_pend_q) begin
            if (match) begin
              found_q <= 1'b1;
            end else begin
              kept_q <= kept_q + 1'b1;
            end
          end
          if (!scan_more && !rd_pend_q) begin
            state_q            <= S_IDLE;
            done_q             <= 1'b1;
            res_q.popped_value <= '0;
            res_q.status       <= siq_pkg::ST_OK;
            if (kind_q == siq_pkg::KIND_REMOVE) begin
              count_q          <= kept_q;
              res_q.found      <= 1'b0;
              res_q.now_empty  <= (kept_q == '0);
              res_q.fill_count <= siq_pkg::FILL_W'(kept_q);
            end else begin
              res_q.found      <= found_q;
              res_q.now_empty  <= (count_q == '0);
              res_q.fill_count <= siq_pkg::FILL_W'(count_q);
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C)
    else $error("fill count above capacity");

  a_append_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i.kind == siq_pkg::KIND_APPEND)) |=> done_o)
    else $error("append result missing");

  a_pop_empty_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status == siq_pkg::ST_POP_EMPTY)) |-> (count_q == '0))
    else $error("pop on empty flagged with entries held");

  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == S_SCAN))
    else $error("read pending outside scan");

  a_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (kept_q <= rd_idx_q))
    else $error("compaction write index passed read index");

endmodule
